FILE: sv/rlsc_pkg.sv
package rlsc_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_TRACK_COUNT = 32;

  localparam int SPAN_W  = 40;
  localparam int END_W   = SPAN_W + 1;
  localparam int WILD_W  = 2;
  localparam int PROPS_W = 3;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 4;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST = 2'd2;

  localparam logic [WILD_W-1:0] WILD_NORMAL = 2'd0;
  localparam logic [WILD_W-1:0] WILD_NONE   = 2'd1;
  localparam logic [WILD_W-1:0] WILD_ALL    = 2'd2;
  localparam logic [WILD_W-1:0] WILD_SPARE  = 2'd3;

  localparam logic [KIND_W-1:0] EDIT_DELETE  = 2'd0;
  localparam logic [KIND_W-1:0] EDIT_INSERT  = 2'd1;
  localparam logic [KIND_W-1:0] EDIT_REPLACE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam int PROP_POSITION = 0;
  localparam int PROP_LENGTH   = 1;
  localparam int PROP_CONTENTS = 2;

  typedef struct packed {
    logic push;
    logic pop;
    logic blank;
    logic load_test;
    logic issue;
    logic finish;
  } rlsc_cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
  } rlsc_sts_t;

  // code three behaves as normal
  function automatic logic [WILD_W-1:0] norm_wild(input logic [WILD_W-1:0] code);
    logic [WILD_W-1:0] res;
    res = (code == WILD_SPARE) ? WILD_NORMAL : code;
    return res;
  endfunction

endpackage

FILE: sv/rlsc_ctrl.sv
module rlsc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rlsc_pkg::MODE_W-1:0]    mode,
  input  rlsc_pkg::rlsc_sts_t            sts,
  output rlsc_pkg::rlsc_cmd_t            cmd,
  output logic                           busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            rlsc_pkg::MODE_PUSH: cmd.push = 1'b1;
            rlsc_pkg::MODE_POP:  cmd.pop  = 1'b1;
            rlsc_pkg::MODE_TEST: begin
              cmd.load_test = 1'b1;
              state_next    = ST_SCAN;
            end
            default: cmd.blank = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // stop on the first hit or once the last fetched entry is checked
        if (sts.hit || !sts.more) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: sv/rlsc_datapath.sv
module rlsc_datapath #(
  parameter int STACK_DEPTH = rlsc_pkg::DEF_STACK_DEPTH,
  parameter int TRACK_COUNT = rlsc_pkg::DEF_TRACK_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rlsc_pkg::rlsc_cmd_t             cmd,
  output rlsc_pkg::rlsc_sts_t             sts,
  input  logic [rlsc_pkg::SPAN_W-1:0]     region_offset,
  input  logic [rlsc_pkg::SPAN_W-1:0]     region_count,
  input  logic [TRACK_COUNT-1:0]          track_mask,
  input  logic [rlsc_pkg::WILD_W-1:0]     mask_wild,
  input  logic [rlsc_pkg::WILD_W-1:0]     span_wild,
  input  logic [rlsc_pkg::PROPS_W-1:0]    protect_props,
  input  logic [rlsc_pkg::TAG_W-1:0]      reason_tag,
  input  logic [rlsc_pkg::KIND_W-1:0]     edit_kind,
  output logic                            done,
  output logic [rlsc_pkg::STAT_W-1:0]     status,
  output logic                            violated,
  output logic [rlsc_pkg::TAG_W-1:0]      hit_tag,
  output logic [rlsc_pkg::DEPTH_W-1:0]    hit_depth
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WC_W  = 2 * rlsc_pkg::WILD_W;

  // entry store
  logic [rlsc_pkg::SPAN_W-1:0]  mem_offset [STACK_DEPTH];
  logic [rlsc_pkg::END_W-1:0]   mem_end    [STACK_DEPTH];
  logic [TRACK_COUNT-1:0]       mem_tracks [STACK_DEPTH];
  logic [WC_W-1:0]              mem_wild   [STACK_DEPTH];
  logic [rlsc_pkg::PROPS_W-1:0] mem_props  [STACK_DEPTH];
  logic [rlsc_pkg::TAG_W-1:0]   mem_reason [STACK_DEPTH];

  logic [rlsc_pkg::SPAN_W-1:0]  rd_offset;
  logic [rlsc_pkg::END_W-1:0]   rd_end;
  logic [TRACK_COUNT-1:0]       rd_tracks;
  logic [WC_W-1:0]              rd_wild;
  logic [rlsc_pkg::PROPS_W-1:0] rd_props;
  logic [rlsc_pkg::TAG_W-1:0]   rd_reason;
  logic [LVL_W-1:0]             rd_depth;
  logic                         rd_vld;

  logic [LVL_W-1:0]             level;
  logic [LVL_W-1:0]             issue_cnt;
  logic [LVL_W-1:0]             rd_idx_full;
  logic [IDX_W-1:0]             rd_idx;
  logic [IDX_W-1:0]             wr_idx;
  logic                         level_zero;
  logic                         level_full;

  // latched test operands
  logic [rlsc_pkg::SPAN_W-1:0]  op_offset;
  logic [rlsc_pkg::END_W-1:0]   op_end;
  logic                         op_count_nz;
  logic [TRACK_COUNT-1:0]       op_tracks;
  logic [rlsc_pkg::WILD_W-1:0]  op_mask_wild;
  logic [rlsc_pkg::WILD_W-1:0]  op_span_wild;
  logic [rlsc_pkg::KIND_W-1:0]  op_kind;

  logic [rlsc_pkg::WILD_W-1:0]  emw;
  logic [rlsc_pkg::WILD_W-1:0]  esw;
  logic                         track_ok;
  logic                         wild_block;
  logic                         span_all;
  logic                         before_start;
  logic                         outside;
  logic                         interval_hit;
  logic                         hit;
  logic [31:0]                  depth_ext;

  assign level_zero  = (level == '0);
  assign level_full  = (level == LVL_W'(STACK_DEPTH));
  assign wr_idx      = level[IDX_W-1:0];
  assign rd_idx_full = level - issue_cnt - LVL_W'(1);
  assign rd_idx      = rd_idx_full[IDX_W-1:0];

  // write on push, fetch one entry per issue, newest first
  always_ff @(posedge clk) begin
    if (cmd.push && !level_full) begin
      mem_offset[wr_idx] <= region_offset;
      mem_end[wr_idx]    <= {1'b0, region_offset} + {1'b0, region_count};
      mem_tracks[wr_idx] <= track_mask;
      mem_wild[wr_idx]   <= {rlsc_pkg::norm_wild(span_wild), rlsc_pkg::norm_wild(mask_wild)};
      mem_props[wr_idx]  <= protect_props;
      mem_reason[wr_idx] <= reason_tag;
    end
    if (cmd.issue) begin
      rd_offset <= mem_offset[rd_idx];
      rd_end    <= mem_end[rd_idx];
      rd_tracks <= mem_tracks[rd_idx];
      rd_wild   <= mem_wild[rd_idx];
      rd_props  <= mem_props[rd_idx];
      rd_reason <= mem_reason[rd_idx];
      rd_depth  <= issue_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      issue_cnt <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cmd.push && !level_full) begin
        level <= level + LVL_W'(1);
      end else if (cmd.pop && !level_zero) begin
        level <= level - LVL_W'(1);
      end
      if (cmd.load_test) begin
        issue_cnt <= '0;
      end else if (cmd.issue) begin
        issue_cnt <= issue_cnt + LVL_W'(1);
      end
      rd_vld <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_test) begin
      op_offset    <= region_offset;
      op_end       <= {1'b0, region_offset} + {1'b0, region_count};
      op_count_nz  <= (region_count != '0);
      op_tracks    <= track_mask;
      op_mask_wild <= rlsc_pkg::norm_wild(mask_wild);
      op_span_wild <= rlsc_pkg::norm_wild(span_wild);
      op_kind      <= edit_kind;
    end
  end

  // rule check on the fetched entry
  always_comb begin
    emw = rd_wild[rlsc_pkg::WILD_W-1:0];
    esw = rd_wild[WC_W-1:rlsc_pkg::WILD_W];
    track_ok = (op_mask_wild == rlsc_pkg::WILD_ALL) || (emw == rlsc_pkg::WILD_ALL) ||
               ((op_tracks & rd_tracks) != '0);
    wild_block = (op_mask_wild == rlsc_pkg::WILD_NONE) || (emw == rlsc_pkg::WILD_NONE) ||
                 (op_span_wild == rlsc_pkg::WILD_NONE) || (esw == rlsc_pkg::WILD_NONE);
    span_all = (op_span_wild == rlsc_pkg::WILD_ALL) || (esw == rlsc_pkg::WILD_ALL);
    before_start = (op_offset < rd_offset);
    outside = (before_start && (op_end < {1'b0, rd_offset})) ||
              (({1'b0, op_offset} > rd_end) && (op_end != '0));
    case (op_kind)
      rlsc_pkg::EDIT_DELETE, rlsc_pkg::EDIT_INSERT: begin
        interval_hit = (rd_props[rlsc_pkg::PROP_POSITION] && before_start && op_count_nz) ||
                       ((rd_props[rlsc_pkg::PROP_LENGTH] || rd_props[rlsc_pkg::PROP_CONTENTS])
                        && !outside);
      end
      rlsc_pkg::EDIT_REPLACE: interval_hit = rd_props[rlsc_pkg::PROP_CONTENTS] && !outside;
      default: interval_hit = 1'b0;
    endcase
    hit = rd_vld && !wild_block && track_ok && (span_all || interval_hit);
  end

  assign sts.hit  = hit;
  assign sts.more = (issue_cnt != level);
  assign depth_ext = 32'(rd_depth);

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.push || cmd.pop || cmd.blank || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.pop || cmd.blank || cmd.finish) begin
      status    <= rlsc_pkg::STAT_OK;
      violated  <= 1'b0;
      hit_tag   <= '0;
      hit_depth <= '0;
      if (cmd.push && level_full) begin
        status <= rlsc_pkg::STAT_FULL;
      end
      if (cmd.pop && level_zero) begin
        status <= rlsc_pkg::STAT_EMPTY;
      end
      if (cmd.finish && hit) begin
        violated  <= 1'b1;
        hit_tag   <= rd_reason;
        hit_depth <= depth_ext[rlsc_pkg::DEPTH_W-1:0];
      end
    end
  end

endmodule

FILE: sv/region_lock_stack_checker.sv
// Region lock stack checker.
// Command channel: drive mode and the region fields and raise start; the word
// is taken at the clock edge where start is high and busy is low. Push stores
// an entry, pop drops the top one, test scans the entries from the newest down
// and reports the first one the edit would violate.
// Result channel: done is high for exactly one cycle with status, violated,
// hit_tag and hit_depth valid in that cycle. The receiver cannot stall, so
// every result must be taken as it appears.
// Timing: push, pop and unused modes strobe done in the cycle after accept
// and keep busy low, so one may be issued every cycle. A test holds busy
// while it scans its entries (stack level, or up to and including the first
// hit) and strobes done in the first cycle that busy is low again; a new
// word can be taken in that cycle. The scan is paced by the single-read-port
// entry store, fetched one entry per cycle with the rule check in the cycle
// after each fetch.
// Reset: the stack is emptied and no result is pending; entry contents are
// not cleared.
module region_lock_stack_checker #(
  parameter int STACK_DEPTH = rlsc_pkg::DEF_STACK_DEPTH,
  parameter int TRACK_COUNT = rlsc_pkg::DEF_TRACK_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rlsc_pkg::MODE_W-1:0]     mode,
  input  logic [rlsc_pkg::SPAN_W-1:0]     region_offset,
  input  logic [rlsc_pkg::SPAN_W-1:0]     region_count,
  input  logic [TRACK_COUNT-1:0]          track_mask,
  input  logic [rlsc_pkg::WILD_W-1:0]     mask_wild,
  input  logic [rlsc_pkg::WILD_W-1:0]     span_wild,
  input  logic [rlsc_pkg::PROPS_W-1:0]    protect_props,
  input  logic [rlsc_pkg::TAG_W-1:0]      reason_tag,
  input  logic [rlsc_pkg::KIND_W-1:0]     edit_kind,
  output logic                            done,
  output logic [rlsc_pkg::STAT_W-1:0]     status,
  output logic                            violated,
  output logic [rlsc_pkg::TAG_W-1:0]      hit_tag,
  output logic [rlsc_pkg::DEPTH_W-1:0]    hit_depth
);

  rlsc_pkg::rlsc_cmd_t cmd;
  rlsc_pkg::rlsc_sts_t sts;

  rlsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rlsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .TRACK_COUNT (TRACK_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .region_offset (region_offset),
    .region_count  (region_count),
    .track_mask    (track_mask),
    .mask_wild     (mask_wild),
    .span_wild     (span_wild),
    .protect_props (protect_props),
    .reason_tag    (reason_tag),
    .edit_kind     (edit_kind),
    .done          (done),
    .status        (status),
    .violated      (violated),
    .hit_tag       (hit_tag),
    .hit_depth     (hit_depth)
  );

endmodule
